// ===== src/assert_macros.svh =====
// assertion helpers shared by the renderer modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define GCTR_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define GCTR_NEVER(lbl, clk, rst_n, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define GCTR_ASSERT(lbl, clk, rst_n, prop, msg)
`define GCTR_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

// ===== src/gctr_pkg.sv =====
package gctr_pkg;

  localparam int XW = 16;
  localparam int YW = 8;
  localparam int CW = 16;
  localparam int FONT_ENTRIES = 98;
  localparam int GLYPH_COLS = 5;
  localparam int IDX_W = $clog2(FONT_ENTRIES);

  localparam logic [7:0] FIRST_CODE = 8'd32;
  localparam logic [7:0] CODE_BS = 8'd8;
  localparam logic [7:0] CODE_TAB = 8'd9;
  localparam logic [7:0] CODE_NL = 8'd10;
  localparam logic [7:0] CODE_VT = 8'd11;
  localparam logic [7:0] CODE_FF = 8'd12;
  localparam logic [7:0] CODE_CR = 8'd13;

  localparam logic [XW-1:0] X_ADVANCE = 16'd6;
  localparam logic [YW-1:0] Y_NL_STEP = 8'd10;
  localparam logic [YW-1:0] Y_TAB_STEP = 8'd30;
  localparam logic [YW-1:0] Y_VT_STEP = 8'd40;

  localparam logic [2:0] LAST_COL = 3'd5;
  localparam logic [2:0] LAST_ROW = 3'd7;

  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_MOVE = 1'b1;

  localparam logic CFG_FONT_COLOR = 1'b0;
  localparam logic CFG_FILL_COLOR = 1'b1;
  localparam logic [CW-1:0] FONT_COLOR_RST = 16'hFFFF;
  localparam logic [CW-1:0] FILL_COLOR_RST = 16'h0000;

  // cursor operations
  localparam logic [3:0] CUR_HOLD = 4'd0;
  localparam logic [3:0] CUR_LOAD = 4'd1;
  localparam logic [3:0] CUR_BS = 4'd2;
  localparam logic [3:0] CUR_HOME = 4'd3;
  localparam logic [3:0] CUR_NL = 4'd4;
  localparam logic [3:0] CUR_CR = 4'd5;
  localparam logic [3:0] CUR_TAB = 4'd6;
  localparam logic [3:0] CUR_VT = 4'd7;
  localparam logic [3:0] CUR_ADV = 4'd8;

  typedef struct packed {
    logic req_type;
    logic [7:0] char_code;
    logic [XW-1:0] new_x;
    logic [YW-1:0] new_y;
  } in_t;

  typedef struct packed {
    logic [XW-1:0] pixel_x;
    logic [YW-1:0] pixel_y;
    logic [CW-1:0] pixel_color;
    logic last_pixel;
  } out_t;

  typedef struct packed {
    logic start;
    logic emit;
    logic [3:0] cur_op;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
    logic last_pix;
  } sts_t;

  localparam logic [7:0] GLYPH_ROM [FONT_ENTRIES][GLYPH_COLS] = '{
    '{8'h00,8'h00,8'h00,8'h00,8'h00}, '{8'h00,8'h00,8'h5F,8'h00,8'h00},
    '{8'h00,8'h03,8'h00,8'h03,8'h00}, '{8'h14,8'h3E,8'h14,8'h3E,8'h14},
    '{8'h24,8'h2A,8'h7F,8'h2A,8'h12}, '{8'h43,8'h33,8'h08,8'h66,8'h61},
    '{8'h36,8'h49,8'h55,8'h22,8'h50}, '{8'h00,8'h05,8'h03,8'h00,8'h00},
    '{8'h00,8'h1C,8'h22,8'h41,8'h00}, '{8'h00,8'h41,8'h22,8'h1C,8'h00},
    '{8'h14,8'h08,8'h3E,8'h08,8'h14}, '{8'h08,8'h08,8'h3E,8'h08,8'h08},
    '{8'h00,8'h50,8'h30,8'h00,8'h00}, '{8'h08,8'h08,8'h08,8'h08,8'h08},
    '{8'h00,8'h60,8'h60,8'h00,8'h00}, '{8'h20,8'h10,8'h08,8'h04,8'h02},
    '{8'h3E,8'h51,8'h49,8'h45,8'h3E}, '{8'h00,8'h04,8'h02,8'h7F,8'h00},
    '{8'h42,8'h61,8'h51,8'h49,8'h46}, '{8'h22,8'h41,8'h49,8'h49,8'h36},
    '{8'h18,8'h14,8'h12,8'h7F,8'h10}, '{8'h27,8'h45,8'h45,8'h45,8'h39},
    '{8'h3E,8'h49,8'h49,8'h49,8'h32}, '{8'h01,8'h01,8'h71,8'h09,8'h07},
    '{8'h36,8'h49,8'h49,8'h49,8'h36}, '{8'h26,8'h49,8'h49,8'h49,8'h3E},
    '{8'h00,8'h36,8'h36,8'h00,8'h00}, '{8'h00,8'h56,8'h36,8'h00,8'h00},
    '{8'h08,8'h14,8'h22,8'h41,8'h00}, '{8'h14,8'h14,8'h14,8'h14,8'h14},
    '{8'h00,8'h41,8'h22,8'h14,8'h08}, '{8'h02,8'h01,8'h51,8'h09,8'h06},
    '{8'h3E,8'h41,8'h59,8'h55,8'h5E}, '{8'h7E,8'h09,8'h09,8'h09,8'h7E},
    '{8'h7F,8'h49,8'h49,8'h49,8'h36}, '{8'h3E,8'h41,8'h41,8'h41,8'h22},
    '{8'h7F,8'h41,8'h41,8'h41,8'h3E}, '{8'h7F,8'h49,8'h49,8'h49,8'h41},
    '{8'h7F,8'h09,8'h09,8'h09,8'h01}, '{8'h3E,8'h41,8'h41,8'h49,8'h3A},
    '{8'h7F,8'h08,8'h08,8'h08,8'h7F}, '{8'h00,8'h41,8'h7F,8'h41,8'h00},
    '{8'h30,8'h40,8'h40,8'h40,8'h3F}, '{8'h7F,8'h08,8'h14,8'h22,8'h41},
    '{8'h7F,8'h40,8'h40,8'h40,8'h40}, '{8'h7F,8'h02,8'h0C,8'h02,8'h7F},
    '{8'h7F,8'h02,8'h04,8'h08,8'h7F}, '{8'h3E,8'h41,8'h41,8'h41,8'h3E},
    '{8'h7F,8'h09,8'h09,8'h09,8'h06}, '{8'h1E,8'h21,8'h21,8'h21,8'h5E},
    '{8'h7F,8'h09,8'h09,8'h09,8'h76}, '{8'h26,8'h49,8'h49,8'h49,8'h32},
    '{8'h01,8'h01,8'h7F,8'h01,8'h01}, '{8'h3F,8'h40,8'h40,8'h40,8'h3F},
    '{8'h1F,8'h20,8'h40,8'h20,8'h1F}, '{8'h7F,8'h20,8'h10,8'h20,8'h7F},
    '{8'h41,8'h22,8'h1C,8'h22,8'h41}, '{8'h07,8'h08,8'h70,8'h08,8'h07},
    '{8'h61,8'h51,8'h49,8'h45,8'h43}, '{8'h00,8'h7F,8'h41,8'h00,8'h00},
    '{8'h02,8'h04,8'h08,8'h10,8'h20}, '{8'h00,8'h00,8'h41,8'h7F,8'h00},
    '{8'h04,8'h02,8'h01,8'h02,8'h04}, '{8'h40,8'h40,8'h40,8'h40,8'h40},
    '{8'h00,8'h01,8'h02,8'h04,8'h00}, '{8'h20,8'h54,8'h54,8'h54,8'h78},
    '{8'h7F,8'h44,8'h44,8'h44,8'h38}, '{8'h38,8'h44,8'h44,8'h44,8'h44},
    '{8'h38,8'h44,8'h44,8'h44,8'h7F}, '{8'h38,8'h54,8'h54,8'h54,8'h18},
    '{8'h04,8'h04,8'h7E,8'h05,8'h05}, '{8'h08,8'h54,8'h54,8'h54,8'h3C},
    '{8'h7F,8'h08,8'h04,8'h04,8'h78}, '{8'h00,8'h44,8'h7D,8'h40,8'h00},
    '{8'h20,8'h40,8'h44,8'h3D,8'h00}, '{8'h7F,8'h10,8'h28,8'h44,8'h00},
    '{8'h00,8'h41,8'h7F,8'h40,8'h00}, '{8'h7C,8'h04,8'h78,8'h04,8'h78},
    '{8'h7C,8'h08,8'h04,8'h04,8'h78}, '{8'h38,8'h44,8'h44,8'h44,8'h38},
    '{8'h7C,8'h14,8'h14,8'h14,8'h08}, '{8'h08,8'h14,8'h14,8'h14,8'h7C},
    '{8'h00,8'h7C,8'h08,8'h04,8'h04}, '{8'h48,8'h54,8'h54,8'h54,8'h20},
    '{8'h04,8'h04,8'h3F,8'h44,8'h44}, '{8'h3C,8'h40,8'h40,8'h20,8'h7C},
    '{8'h1C,8'h20,8'h40,8'h20,8'h1C}, '{8'h3C,8'h40,8'h30,8'h40,8'h3C},
    '{8'h44,8'h28,8'h10,8'h28,8'h44}, '{8'h0C,8'h50,8'h50,8'h50,8'h3C},
    '{8'h44,8'h64,8'h54,8'h4C,8'h44}, '{8'h00,8'h08,8'h36,8'h41,8'h41},
    '{8'h00,8'h00,8'h7F,8'h00,8'h00}, '{8'h41,8'h41,8'h36,8'h08,8'h00},
    '{8'h02,8'h01,8'h02,8'h04,8'h02}, '{8'h04,8'h02,8'hFF,8'h02,8'h04},
    '{8'h20,8'h40,8'hFF,8'h40,8'h20}, '{8'h00,8'h00,8'h00,8'h00,8'h00}
  };

endpackage

// ===== src/gctr_ctrl.sv =====
`include "assert_macros.svh"

module gctr_ctrl #(
  parameter int GLYPH_COUNT = 98
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  gctr_pkg::in_t   in_data,
  output logic            in_stall,
  input  gctr_pkg::sts_t  sts,
  output gctr_pkg::cmd_t  cmd
);
  import gctr_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DRAW = 1'b1;
  localparam logic [7:0] LAST_CODE = 8'(int'(FIRST_CODE) + GLYPH_COUNT - 1);

  logic state_r, state_nxt;
  logic accept;
  logic printable;

  assign in_stall = (state_r == ST_DRAW);
  assign accept = in_valid && !in_stall;
  assign printable = (in_data.char_code >= FIRST_CODE) && (in_data.char_code <= LAST_CODE);

  always_comb begin
    state_nxt = state_r;
    cmd.start = 1'b0;
    cmd.emit = 1'b0;
    cmd.cur_op = CUR_HOLD;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_data.req_type == REQ_MOVE) begin
            cmd.cur_op = CUR_LOAD;
          end else begin
            unique case (in_data.char_code)
              CODE_BS:  cmd.cur_op = CUR_BS;
              CODE_FF:  cmd.cur_op = CUR_HOME;
              CODE_NL:  cmd.cur_op = CUR_NL;
              CODE_CR:  cmd.cur_op = CUR_CR;
              CODE_TAB: cmd.cur_op = CUR_TAB;
              CODE_VT:  cmd.cur_op = CUR_VT;
              default: begin
                if (printable) begin
                  cmd.start = 1'b1;
                  state_nxt = ST_DRAW;
                end
              end
            endcase
          end
        end
      end
      ST_DRAW: begin
        if (!sts.out_busy) begin
          cmd.emit = 1'b1;
          if (sts.last_pix) begin
            cmd.cur_op = CUR_ADV;
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  `GCTR_ASSERT(a_start_enters_draw, clk, rst_n, cmd.start |=> (state_r == ST_DRAW), "no draw")
  `GCTR_NEVER(a_emit_only_in_draw, clk, rst_n, cmd.emit && (state_r != ST_DRAW), "stray pixel")
  `GCTR_ASSERT(a_last_ends_draw, clk, rst_n, (cmd.emit && sts.last_pix) |=> !in_stall, "no end")

endmodule

// ===== src/gctr_dp.sv =====
`include "assert_macros.svh"

module gctr_dp (
  input  logic            clk,
  input  logic            rst_n,
  input  gctr_pkg::in_t   in_data,
  input  logic            cfg_we,
  input  logic            cfg_idx,
  input  logic [15:0]     cfg_wdata,
  input  gctr_pkg::cmd_t  cmd,
  output gctr_pkg::sts_t  sts,
  output logic            out_valid,
  output gctr_pkg::out_t  out_data,
  input  logic            out_stall
);
  import gctr_pkg::*;

  logic [CW-1:0] font_color_r, fill_color_r;
  logic [XW-1:0] cur_x_r, cur_x_nxt;
  logic [YW-1:0] cur_y_r, cur_y_nxt;
  logic [IDX_W-1:0] idx_r;
  logic [2:0] col_r, col_nxt;
  logic [2:0] row_r, row_nxt;
  logic out_valid_r, out_valid_nxt;
  out_t out_data_r, pix;
  logic [7:0] col_bits;
  logic [7:0] code_off;

  assign code_off = in_data.char_code - FIRST_CODE;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      font_color_r <= FONT_COLOR_RST;
      fill_color_r <= FILL_COLOR_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_FONT_COLOR: font_color_r <= cfg_wdata;
        CFG_FILL_COLOR: fill_color_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // cursor update
  always_comb begin
    cur_x_nxt = cur_x_r;
    cur_y_nxt = cur_y_r;
    unique case (cmd.cur_op)
      CUR_HOLD: ;
      CUR_LOAD: begin
        cur_x_nxt = in_data.new_x;
        cur_y_nxt = in_data.new_y;
      end
      CUR_BS:   cur_x_nxt = cur_x_r - X_ADVANCE;
      CUR_HOME: begin
        cur_x_nxt = '0;
        cur_y_nxt = '0;
      end
      CUR_NL: begin
        cur_x_nxt = '0;
        cur_y_nxt = cur_y_r + Y_NL_STEP;
      end
      CUR_CR:   cur_x_nxt = '0;
      CUR_TAB:  cur_y_nxt = cur_y_r + Y_TAB_STEP;
      CUR_VT: begin
        cur_x_nxt = '0;
        cur_y_nxt = cur_y_r + Y_VT_STEP;
      end
      CUR_ADV:  cur_x_nxt = cur_x_r + X_ADVANCE;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_x_r <= '0;
      cur_y_r <= '0;
    end else begin
      cur_x_r <= cur_x_nxt;
      cur_y_r <= cur_y_nxt;
    end
  end

  // glyph scan counters
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (cmd.start) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (cmd.emit) begin
      row_nxt = row_r + 3'd1;
      if (row_r == LAST_ROW) begin
        col_nxt = col_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    col_r <= col_nxt;
    row_r <= row_nxt;
    if (cmd.start) begin
      idx_r <= code_off[IDX_W-1:0];
    end
  end

  // spacing column reads as blank
  assign col_bits = (col_r < LAST_COL) ? GLYPH_ROM[idx_r][col_r] : 8'h00;

  always_comb begin
    pix.pixel_x = cur_x_r + {{(XW-3){1'b0}}, col_r};
    pix.pixel_y = cur_y_r + {{(YW-3){1'b0}}, row_r};
    pix.pixel_color = col_bits[row_r] ? font_color_r : fill_color_r;
    pix.last_pixel = sts.last_pix;
  end

  assign sts.last_pix = (col_r == LAST_COL) && (row_r == LAST_ROW);
  assign sts.out_busy = out_valid_r && out_stall;

  // output register
  assign out_valid_nxt = cmd.emit || (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_data_r <= pix;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  `GCTR_NEVER(a_no_overwrite, clk, rst_n, cmd.emit && out_valid_r && out_stall, "stalled pixel overwritten")
  `GCTR_ASSERT(a_last_flag, clk, rst_n, (cmd.emit && sts.last_pix) |=> out_data_r.last_pixel, "last pixel flag missing")
  `GCTR_ASSERT(a_scan_restart, clk, rst_n, cmd.start |=> (col_r == 3'd0 && row_r == 3'd0), "scan did not restart")

endmodule

// ===== src/glyph_cursor_text_renderer.sv =====
// latency: move and control requests update the cursor at the accepting edge
// printable glyph: pixels reach out_valid through the output register
// throughput: 48 pixels at one per cycle unless out_stall holds the output
// a printable character holds in_stall until its last pixel is emitted
// reset: synchronous active-low; cursor at 0,0, font color ffff, fill color 0
module glyph_cursor_text_renderer #(
  parameter int GLYPH_COUNT = 98
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  gctr_pkg::in_t   in_data,
  output logic            in_stall,
  output logic            out_valid,
  output gctr_pkg::out_t  out_data,
  input  logic            out_stall,
  input  logic            cfg_we,
  input  logic            cfg_idx,
  input  logic [15:0]     cfg_wdata
);
  import gctr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gctr_ctrl #(
    .GLYPH_COUNT(GLYPH_COUNT)
  ) u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_data(in_data),
    .in_stall(in_stall),
    .sts(sts),
    .cmd(cmd)
  );

  gctr_dp u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .in_data(in_data),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata),
    .cmd(cmd),
    .sts(sts),
    .out_valid(out_valid),
    .out_data(out_data),
    .out_stall(out_stall)
  );

endmodule
